// File: hdl/tsi_pkg.sv
// tsi_pkg: shared constants and types for the tolerant set intersection
// no dependencies
`default_nettype none
package tsi_pkg;
  localparam int StoreDepth = 256;
  localparam int ValBits    = 25;
  localparam int TolBits    = 21;
  localparam int CntBits    = 9;
  localparam int IdxBits    = 8;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PROBE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [TolBits-1:0] TolReset = 21'd1;

  // true when |a - b| < tol
  function automatic logic near_eq(input logic signed [ValBits-1:0] a,
                                   input logic signed [ValBits-1:0] b,
                                   input logic [TolBits-1:0] tol);
    logic signed [ValBits:0] d;
    logic [ValBits:0] mag;
    begin
      d = {a[ValBits-1], a} - {b[ValBits-1], b};
      mag = d[ValBits] ? (~d + 1'b1) : d;
      near_eq = mag < {{(ValBits+1-TolBits){1'b0}}, tol};
    end
  endfunction

  // token walking the chain of found cells
  typedef struct packed {
    logic                      vld;
    logic                      hit;
    logic signed [ValBits-1:0] val;
  } tok_t;
endpackage
`default_nettype wire

// File: hdl/tsi_cell.sv
// tsi_cell: one slot of the found list; compares the passing request
// depends on tsi_pkg
`default_nettype none
module tsi_cell (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              clr,
  input  wire logic                              wr,
  input  wire logic signed [tsi_pkg::ValBits-1:0] wr_val,
  input  wire logic [tsi_pkg::TolBits-1:0]        tol,
  input  wire tsi_pkg::tok_t                      tin,
  output tsi_pkg::tok_t                           tout
);
  logic                              full;
  logic signed [tsi_pkg::ValBits-1:0] slot;

  // slot storage
  always_ff @(posedge clk) begin
    if (rst || clr) full <= 1'b0;
    else if (wr) full <= 1'b1;
    if (wr) slot <= wr_val;
  end

  // pass token on, marking a hit
  always_ff @(posedge clk) begin
    if (rst) tout.vld <= 1'b0;
    else tout.vld <= tin.vld;
    tout.val <= tin.val;
    tout.hit <= tin.hit | (full & tsi_pkg::near_eq(tin.val, slot, tol));
  end
endmodule
`default_nettype wire

// File: hdl/tolerant_set_intersection.sv
// tolerant_set_intersection: top level, second-array memory and scan sequencer
// depends on tsi_pkg, tsi_cell
// load/clear: accepted back to back. probe: a read, a test and an emit step per stored
// entry, plus, for each entry within tolerance of the probe, a walk of the
// 256-cell found chain (one cell per cycle) before its emit step.
// a probe of an empty store stays idle.
// results are held in an output register; a stalled output holds the scan.
// reset: fill counts, found list and the drop flag behind overflow cleared, tolerance set to 1.
`default_nettype none
module tolerant_set_intersection (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tsi_pkg::TolBits-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         operation,
  input  wire logic signed [tsi_pkg::ValBits-1:0] value,
  output logic                                    out_valid,
  input  wire logic                              out_stall,
  output logic signed [tsi_pkg::ValBits-1:0]      matched_value,
  output logic signed [tsi_pkg::ValBits-1:0]      probe_value,
  output logic [tsi_pkg::CntBits-1:0]             match_count,
  output logic                                    last_of_run,
  output logic                                    overflow
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_READ = 5'b00010, S_TEST = 5'b00100,
    S_WALK = 5'b01000, S_EMIT = 5'b10000
  } st_t;

  localparam int N = tsi_pkg::StoreDepth;

  st_t                               st;
  logic [tsi_pkg::TolBits-1:0]        tol;
  logic [tsi_pkg::CntBits-1:0]        sfill, ffill;
  logic                               dropped;
  logic signed [tsi_pkg::ValBits-1:0] mem [N];
  logic signed [tsi_pkg::ValBits-1:0] rd, probe;
  logic [tsi_pkg::CntBits-1:0]        j;
  logic [tsi_pkg::CntBits-1:0]        wcnt;
  logic                               pend;      // a result held for last flag
  logic signed [tsi_pkg::ValBits-1:0] pend_val;
  logic [tsi_pkg::CntBits-1:0]        pend_cnt;
  logic                               clr;
  logic [N-1:0]                       cwr;
  tsi_pkg::tok_t                      tok [N+1];
  logic                               acc, oacc;
  logic                               emit_mid, emit_end;
  tsi_pkg::op_t                       op;

  assign op = tsi_pkg::op_t'(operation);
  assign cfg_ready = (st == S_IDLE) && !pend;
  assign in_stall = !((st == S_IDLE) && !pend);
  assign acc = in_valid && !in_stall;
  assign oacc = out_valid && !out_stall;
  assign clr = acc && (op == tsi_pkg::OP_CLEAR);

  // output register loads: held result on a new match, or last one at scan end
  assign emit_mid = (st == S_WALK) && (wcnt == tsi_pkg::CntBits'(N)) &&
                    !tok[N].hit && !ffill[tsi_pkg::CntBits-1] && pend;
  assign emit_end = (st == S_EMIT) && (!out_valid || oacc) &&
                    !(j + 1'b1 < sfill) && pend;

  // chain of found-list cells
  assign tok[0].vld = (st == S_TEST) && tsi_pkg::near_eq(probe, rd, tol);
  assign tok[0].hit = 1'b0;
  assign tok[0].val = rd;
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      assign cwr[g] = (st == S_WALK) && (wcnt == tsi_pkg::CntBits'(N)) &&
                      !tok[N].hit && (ffill[tsi_pkg::IdxBits-1:0] ==
                      tsi_pkg::IdxBits'(g)) && !ffill[tsi_pkg::CntBits-1];
      tsi_cell u_cell (.clk(clk), .rst(rst), .clr(clr), .wr(cwr[g]),
                       .wr_val(rd), .tol(tol), .tin(tok[g]), .tout(tok[g+1]));
    end
  endgenerate

  // config register
  always_ff @(posedge clk) begin
    if (rst) tol <= tsi_pkg::TolReset;
    else if (cfg_valid && cfg_ready) tol <= cfg_data;
  end

  // memory read port
  always_ff @(posedge clk) begin
    rd <= mem[j[tsi_pkg::IdxBits-1:0]];
    if (acc && op == tsi_pkg::OP_LOAD && !sfill[tsi_pkg::CntBits-1])
      mem[sfill[tsi_pkg::IdxBits-1:0]] <= value;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; sfill <= '0; ffill <= '0; dropped <= 1'b0;
      out_valid <= 1'b0; pend <= 1'b0; j <= '0; wcnt <= '0;
    end else begin
      if (emit_mid || emit_end) out_valid <= 1'b1;
      else if (oacc) out_valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (acc) begin
            case (op)
              tsi_pkg::OP_LOAD: begin
                if (sfill[tsi_pkg::CntBits-1]) dropped <= 1'b1;
                else sfill <= sfill + 1'b1;
              end
              tsi_pkg::OP_CLEAR: begin
                sfill <= '0; ffill <= '0; dropped <= 1'b0;
              end
              tsi_pkg::OP_PROBE: begin
                probe <= value; j <= '0;
                if (sfill != '0) st <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: st <= S_TEST;
        S_TEST: begin
          wcnt <= '0;
          if (tsi_pkg::near_eq(probe, rd, tol)) st <= S_WALK;
          else st <= S_EMIT;
        end
        S_WALK: begin
          wcnt <= wcnt + 1'b1;
          if (wcnt == tsi_pkg::CntBits'(N)) begin
            st <= S_EMIT;
            if (!tok[N].hit && !ffill[tsi_pkg::CntBits-1]) begin
              ffill <= ffill + 1'b1;
              pend <= 1'b1; pend_val <= rd; pend_cnt <= ffill + 1'b1;
              // previous held result goes out, not last
              if (pend) begin
                matched_value <= pend_val;
                probe_value <= probe; match_count <= pend_cnt;
                last_of_run <= 1'b0; overflow <= dropped;
              end
            end
          end
        end
        S_EMIT: begin
          // advance scan; wait for output register to drain first
          if (!out_valid || oacc) begin
            if (j + 1'b1 < sfill) begin
              j <= j + 1'b1; st <= S_READ;
            end else begin
              st <= S_IDLE;
              if (pend) begin
                matched_value <= pend_val;
                probe_value <= probe; match_count <= pend_cnt;
                last_of_run <= 1'b1; overflow <= dropped;
                pend <= 1'b0;
              end
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
